// ===== rtl/core/dtam_pkg.sv =====
// ----------------------------------------------------------------------------
// dtam_pkg - shared definitions for the date-time minute adder
// Calendar limits, divider control struct and the month length function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dtam_pkg;

    // Default width of the minute count
    localparam int ADD_WIDTH_DEF = 24;

    // Calendar limits
    localparam logic [13:0] YEAR_MAX    = 14'd9999;
    localparam logic [3:0]  MON_JAN     = 4'd1;
    localparam logic [3:0]  MON_FEB     = 4'd2;
    localparam logic [3:0]  MON_DEC     = 4'd12;
    localparam logic [4:0]  DAY_FIRST   = 5'd1;
    localparam logic [4:0]  DAY_LAST    = 5'd31;
    localparam logic [4:0]  HOUR_LAST   = 5'd23;
    localparam logic [5:0]  MINUTE_LAST = 6'd59;

    // Divisors used by the shared divider
    localparam logic [5:0]  MIN_PER_HOUR = 6'd60;
    localparam logic [5:0]  HOUR_PER_DAY = 6'd24;

    // Year mod 25 by reciprocal multiply: q = (y * YEAR_RECIP) >> YEAR_SHIFT
    localparam int          YEAR_SHIFT = 19;
    localparam logic [14:0] YEAR_RECIP = 15'((2**YEAR_SHIFT + 24) / 25);
    localparam logic [4:0]  YEAR_M25_LAST = 5'd24;

    // Control from the sequencer to the shared divider
    typedef struct packed {
        logic start;     // load dividend and begin
        logic by_hours;  // 1: divide by 24, 0: divide by 60
    } t_div_ctl;

    // Days in a month; mon is 1..12
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        if (mon == MON_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (mon inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            len = 5'd30;
        end else begin
            len = DAY_LAST;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dtam_cdiv.sv =====
// ----------------------------------------------------------------------------
// dtam_cdiv - divider by 60 or 24
// Drops the power-of-two factor by a shift, then divides by 15 or 3 with a
// reciprocal multiply; start passes through r_st1 and r_st2 to done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtam_cdiv #(
    parameter int DW = dtam_pkg::ADD_WIDTH_DEF + 1
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  dtam_pkg::t_div_ctl  i_ctl,
    input  wire  [DW-1:0]       i_dividend,
    output logic                o_done,
    output logic [DW-1:0]       o_quot,
    output logic [5:0]          o_rem
);
    import dtam_pkg::*;

    // Operand width after the shift, reciprocal width and product width
    localparam int VW = DW - 2;
    localparam int MW = VW + 1;
    localparam int PW = VW + MW;

    // Reciprocals of 15 and 3, exact for every VW-bit operand
    localparam int            SH15    = VW + 4;
    localparam int            SH3     = VW + 2;
    localparam logic [MW-1:0] RECIP15 = MW'(((64'd1 << SH15) + 64'd14) / 64'd15);
    localparam logic [MW-1:0] RECIP3  = MW'(((64'd1 << SH3) + 64'd2) / 64'd3);

    logic [VW-1:0] r_v;
    logic [DW-1:0] r_x;
    logic          r_hours;
    logic          r_st1;
    logic [PW-1:0] r_prod;
    logic          r_st2;
    logic [DW-1:0] r_q;
    logic [5:0]    r_rem;
    logic          r_done;

    // Quotient from the product, remainder by multiply back and subtract
    logic [DW-1:0] quot;
    logic [DW-1:0] back;
    assign quot = r_hours ? DW'(r_prod >> SH3) : DW'(r_prod >> SH15);
    assign back = r_hours ? quot * DW'(HOUR_PER_DAY) : quot * DW'(MIN_PER_HOUR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st1  <= 1'b0;
            r_st2  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_st1  <= i_ctl.start;
            r_st2  <= r_st1;
            r_done <= r_st2;
            // load: 60 = 4 * 15, 24 = 8 * 3
            if (i_ctl.start) begin
                r_x     <= i_dividend;
                r_hours <= i_ctl.by_hours;
                r_v     <= i_ctl.by_hours ? VW'(i_dividend >> 3) : VW'(i_dividend >> 2);
            end
            // multiply by the reciprocal
            if (r_st1) begin
                r_prod <= r_v * (r_hours ? RECIP3 : RECIP15);
            end
            // quotient and remainder
            if (r_st2) begin
                r_q   <= quot;
                r_rem <= 6'(r_x - back);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== rtl/core/date_time_add_minutes.sv =====
// ----------------------------------------------------------------------------
// date_time_add_minutes - add a minute count to a Gregorian date-time
// Carries minutes into hours and days, then walks the days month by month.
// ----------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  in       i_valid / o_stall     i_start_year..i_start_minute, i_add_minutes
//  out      o_valid / i_stall     o_new_year..o_new_minute, o_year_overflow
//
//  One transaction at a time; o_stall is high from accept until the result
//  is taken. The sequencer steps through S_MOD and S_FIX, then two passes
//  through the shared divider, then walks one month boundary per cycle in
//  S_WALK; up to about 385 boundaries are crossed for a full 24-bit count.
//  Synchronous active-low reset returns the sequencer to idle.
//  A result waiting under i_stall is held until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module date_time_add_minutes #(
    parameter int ADD_WIDTH = dtam_pkg::ADD_WIDTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire  [13:0]          i_start_year,
    input  wire  [3:0]           i_start_month,
    input  wire  [4:0]           i_start_day,
    input  wire  [4:0]           i_start_hour,
    input  wire  [5:0]           i_start_minute,
    input  wire  [ADD_WIDTH-1:0] i_add_minutes,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [13:0]          o_new_year,
    output logic [3:0]           o_new_month,
    output logic [4:0]           o_new_day,
    output logic [4:0]           o_new_hour,
    output logic [5:0]           o_new_minute,
    output logic                 o_year_overflow
);
    import dtam_pkg::*;

    localparam int DW = ADD_WIDTH + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_FIX, S_DIV1, S_WAIT1, S_DIV2, S_WAIT2, S_WALK, S_DONE
    } t_state;

    t_state                r_state;
    logic [13:0]           r_year;
    logic [3:0]            r_mon;
    logic [4:0]            r_day;
    logic [4:0]            r_hour;
    logic [5:0]            r_minute;
    logic [ADD_WIDTH-1:0]  r_add;
    logic [4:0]            r_ym25;
    logic [DW-1:0]         r_days;
    logic                  r_ovf;

    // Year mod 25 by reciprocal multiply
    logic [27:0] ym_prod;
    logic [8:0]  ym_quot;
    logic [13:0] ym_rem;
    assign ym_prod = 28'(r_year * YEAR_RECIP);
    assign ym_quot = ym_prod[27:19];
    assign ym_rem  = r_year - 14'(ym_quot * 5'd25);

    // Leap year from low year bits and year mod 25
    logic       leap;
    logic [4:0] dim;
    logic [4:0] gap;
    assign leap = (r_year[1:0] == 2'd0) && ((r_ym25 != 5'd0) || (r_year[3:2] == 2'd0));
    assign dim  = month_len(r_mon, leap);
    assign gap  = dim - r_day;

    // Shared divider
    t_div_ctl      div_ctl;
    logic [DW-1:0] div_dividend;
    logic          div_done;
    logic [DW-1:0] div_quot;
    logic [5:0]    div_rem;

    assign div_ctl.start    = (r_state == S_DIV1) || (r_state == S_DIV2);
    assign div_ctl.by_hours = (r_state == S_DIV2);
    assign div_dividend     = (r_state == S_DIV2) ? div_quot + DW'(r_hour)
                                                  : DW'(r_minute) + DW'(r_add);

    dtam_cdiv #(
        .DW(DW)
    ) u_cdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_dividend),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Sequencer and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovf   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_year   <= (i_start_year > YEAR_MAX) ? YEAR_MAX : i_start_year;
                        r_mon    <= (i_start_month == 4'd0) ? MON_JAN :
                                    (i_start_month > MON_DEC) ? MON_DEC : i_start_month;
                        r_day    <= (i_start_day == 5'd0) ? DAY_FIRST : i_start_day;
                        r_hour   <= (i_start_hour > HOUR_LAST) ? HOUR_LAST : i_start_hour;
                        r_minute <= (i_start_minute > MINUTE_LAST) ? MINUTE_LAST
                                                                   : i_start_minute;
                        r_add    <= i_add_minutes;
                        r_ovf    <= 1'b0;
                        r_state  <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_ym25  <= ym_rem[4:0];
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    // day beyond month end becomes the last day
                    if (r_day > dim) begin
                        r_day <= dim;
                    end
                    r_state <= S_DIV1;
                end
                S_DIV1: begin
                    r_state <= S_WAIT1;
                end
                S_WAIT1: begin
                    if (div_done) begin
                        r_minute <= div_rem;
                        r_state  <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    r_state <= S_WAIT2;
                end
                S_WAIT2: begin
                    if (div_done) begin
                        r_hour  <= div_rem[4:0];
                        r_days  <= div_quot;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    // one month boundary per cycle
                    if (r_days == '0) begin
                        r_state <= S_DONE;
                    end else if (r_days > DW'(gap)) begin
                        r_days <= r_days - DW'(gap) - DW'(1);
                        r_day  <= DAY_FIRST;
                        if (r_mon == MON_DEC) begin
                            if (r_year == YEAR_MAX) begin
                                // saturate past the last representable year
                                r_ovf    <= 1'b1;
                                r_mon    <= MON_DEC;
                                r_day    <= DAY_LAST;
                                r_hour   <= HOUR_LAST;
                                r_minute <= MINUTE_LAST;
                                r_state  <= S_DONE;
                            end else begin
                                r_mon  <= MON_JAN;
                                r_year <= r_year + 14'd1;
                                r_ym25 <= (r_ym25 == YEAR_M25_LAST) ? 5'd0 : r_ym25 + 5'd1;
                            end
                        end else begin
                            r_mon <= r_mon + 4'd1;
                        end
                    end else begin
                        r_day   <= r_day + r_days[4:0];
                        r_days  <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Ports
    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_DONE);
    assign o_new_year      = r_year;
    assign o_new_month     = r_mon;
    assign o_new_day       = r_day;
    assign o_new_hour      = r_hour;
    assign o_new_minute    = r_minute;
    assign o_year_overflow = r_ovf;

    // Checks
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result shown while input side open");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_year_overflow) |-> (o_new_year == YEAR_MAX && o_new_month == MON_DEC
            && o_new_day == DAY_LAST && o_new_hour == HOUR_LAST
            && o_new_minute == MINUTE_LAST))
        else $error("overflow result not saturated");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_new_month >= MON_JAN && o_new_month <= MON_DEC
            && o_new_day >= DAY_FIRST && o_new_hour <= HOUR_LAST
            && o_new_minute <= MINUTE_LAST && o_new_year <= YEAR_MAX))
        else $error("result field out of range");

endmodule

`default_nettype wire

// ===== tb/sv/dtam_checker.sv =====
// ----------------------------------------------------------------------------
// dtam_checker - result checker for the date-time minute adder
// Watches both channels of the adder. Each accepted input transaction is run
// through a calendar predictor and queued; each accepted result is compared
// field by field against the oldest queued prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtam_checker #(
    parameter int ADD_WIDTH = dtam_pkg::ADD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [13:0]          i_start_year,
    input  logic [3:0]           i_start_month,
    input  logic [4:0]           i_start_day,
    input  logic [4:0]           i_start_hour,
    input  logic [5:0]           i_start_minute,
    input  logic [ADD_WIDTH-1:0] i_add_minutes,
    // output channel
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [13:0]          i_new_year,
    input  logic [3:0]           i_new_month,
    input  logic [4:0]           i_new_day,
    input  logic [4:0]           i_new_hour,
    input  logic [5:0]           i_new_minute,
    input  logic                 i_year_overflow,
    // status to the testbench top
    output int                   o_fail_count,
    output int                   o_pending
);

    import dtam_pkg::*;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic        overflow;
    } t_date_time;

    t_date_time expected_dates[$];
    int         mismatches;

    initial begin
        mismatches = 0;
    end

    // Gregorian month length
    function automatic int unsigned days_in_month(input int unsigned mon,
                                                  input int unsigned year);
        bit leap;
        leap = ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
        if (mon == MON_FEB)
            return leap ? 29 : 28;
        if (mon == 4 || mon == 6 || mon == 9 || mon == 11)
            return 30;
        return DAY_LAST;
    endfunction

    // Date-time reached after adding the minute count
    function automatic t_date_time add_minutes_to_date(
        input logic [13:0]          y_in,
        input logic [3:0]           mon_in,
        input logic [4:0]           day_in,
        input logic [4:0]           hour_in,
        input logic [5:0]           min_in,
        input logic [ADD_WIDTH-1:0] add_in
    );
        int unsigned     year, mon, day, hour, minute, dim;
        longint unsigned total, days;
        t_date_time      res;

        // clamp start fields into range
        year   = (y_in > YEAR_MAX) ? YEAR_MAX : y_in;
        mon    = (mon_in == 0) ? MON_JAN : ((mon_in > MON_DEC) ? MON_DEC : mon_in);
        dim    = days_in_month(mon, year);
        day    = (day_in == 0) ? DAY_FIRST : day_in;
        if (day > dim)
            day = dim;
        hour   = (hour_in > HOUR_LAST) ? HOUR_LAST : hour_in;
        minute = (min_in > MINUTE_LAST) ? MINUTE_LAST : min_in;

        // minute and hour carries
        total  = longint'(minute) + longint'(add_in);
        minute = 32'(total % MIN_PER_HOUR);
        total  = total / MIN_PER_HOUR + hour;
        hour   = 32'(total % HOUR_PER_DAY);
        days   = total / HOUR_PER_DAY;

        // day walk, one month per step
        res.overflow = 1'b0;
        while (days != 0 && !res.overflow) begin
            dim = days_in_month(mon, year);
            if (longint'(dim - day) < days) begin
                days -= longint'(dim - day) + 1;
                day   = DAY_FIRST;
                if (mon == MON_DEC) begin
                    mon  = MON_JAN;
                    year = year + 1;
                    if (year > YEAR_MAX)
                        res.overflow = 1'b1;
                end else begin
                    mon = mon + 1;
                end
            end else begin
                day  = day + 32'(days);
                days = 0;
            end
        end

        if (res.overflow) begin
            res.year   = YEAR_MAX;
            res.month  = MON_DEC;
            res.day    = DAY_LAST;
            res.hour   = HOUR_LAST;
            res.minute = MINUTE_LAST;
        end else begin
            res.year   = 14'(year);
            res.month  = 4'(mon);
            res.day    = 5'(day);
            res.hour   = 5'(hour);
            res.minute = 6'(minute);
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: results are matched first, since a result on the same edge
    // always belongs to an earlier transaction
    always @(posedge i_clk) begin : monitor
        t_date_time want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_dates.size() == 0) begin
                    $error("result with no transaction outstanding: %0d-%0d-%0d %0d:%0d",
                           i_new_year, i_new_month, i_new_day, i_new_hour,
                           i_new_minute);
                    mismatches++;
                end else begin
                    want = expected_dates.pop_front();
                    check_field("new_year", want.year, i_new_year);
                    check_field("new_month", want.month, i_new_month);
                    check_field("new_day", want.day, i_new_day);
                    check_field("new_hour", want.hour, i_new_hour);
                    check_field("new_minute", want.minute, i_new_minute);
                    check_field("year_overflow", want.overflow, i_year_overflow);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_dates.push_back(add_minutes_to_date(
                    i_start_year, i_start_month, i_start_day,
                    i_start_hour, i_start_minute, i_add_minutes));
            end
        end
        o_pending    <= expected_dates.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/sv/tb_date_time_add_minutes.sv =====
// ----------------------------------------------------------------------------
// tb_date_time_add_minutes - testbench for the date-time minute adder
// Drives directed calendar corner cases (leap rules, month and year wraps,
// saturation, out-of-range start fields) and then random date-times with a
// mix of short and long minute counts, under random idle and stall bursts.
// Checking is done by dtam_checker; this top makes stimulus and the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_date_time_add_minutes;

    import dtam_pkg::*;

    localparam int ADD_W      = ADD_WIDTH_DEF;
    localparam int NUM_RANDOM = 1500;
    localparam int NUM_QUIET  = 150;   // tail of the run with no idling
    localparam int IDLE_LIMIT = 4000;  // channel-idle limit for the watchdog
    localparam int DRAIN_WAIT = 500;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [13:0]      start_year;
    logic [3:0]       start_month;
    logic [4:0]       start_day;
    logic [4:0]       start_hour;
    logic [5:0]       start_minute;
    logic [ADD_W-1:0] add_minutes;
    logic             out_valid;
    logic             out_stall;
    logic [13:0]      new_year;
    logic [3:0]       new_month;
    logic [4:0]       new_day;
    logic [4:0]       new_hour;
    logic [5:0]       new_minute;
    logic             year_overflow;
    int               fail_count;
    int               pending;
    bit               quiet;

    date_time_add_minutes #(
        .ADD_WIDTH(ADD_W)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_start_year   (start_year),
        .i_start_month  (start_month),
        .i_start_day    (start_day),
        .i_start_hour   (start_hour),
        .i_start_minute (start_minute),
        .i_add_minutes  (add_minutes),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_new_year     (new_year),
        .o_new_month    (new_month),
        .o_new_day      (new_day),
        .o_new_hour     (new_hour),
        .o_new_minute   (new_minute),
        .o_year_overflow(year_overflow)
    );

    dtam_checker #(
        .ADD_WIDTH(ADD_W)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_start_year   (start_year),
        .i_start_month  (start_month),
        .i_start_day    (start_day),
        .i_start_hour   (start_hour),
        .i_start_minute (start_minute),
        .i_add_minutes  (add_minutes),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_new_year     (new_year),
        .i_new_month    (new_month),
        .i_new_day      (new_day),
        .i_new_hour     (new_hour),
        .i_new_minute   (new_minute),
        .i_year_overflow(year_overflow),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stall bursts; out_stall drops between bursts
    initial begin
        out_stall = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // Watchdog: cycles with no transaction on either channel
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_date_time_add_minutes failed");
        $finish;
    end

    // Send one transaction; valid stays high into the next one unless a gap
    // is drawn
    task automatic send_date(input logic [13:0] y, input logic [3:0] mon,
                             input logic [4:0] day, input logic [4:0] hour,
                             input logic [5:0] minute, input logic [ADD_W-1:0] add);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        start_year   = y;
        start_month  = mon;
        start_day    = day;
        start_hour   = hour;
        start_minute = minute;
        add_minutes  = add;
        in_valid     = 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        @(negedge clk);
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        logic [13:0]      y;
        logic [3:0]       mon;
        logic [4:0]       day;
        logic [4:0]       hour;
        logic [5:0]       minute;
        logic [ADD_W-1:0] add;
        logic [4:0]       dim;
        logic             leap;
        int               sel;

        quiet        = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        start_year   = '0;
        start_month  = '0;
        start_day    = '0;
        start_hour   = '0;
        start_minute = '0;
        add_minutes  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: range extremes
        send_date(14'd0, 4'd1, 5'd1, 5'd0, 6'd0, '0);
        send_date(14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, '0);
        send_date(14'd0, 4'd1, 5'd1, 5'd0, 6'd0, {ADD_W{1'b1}});
        // saturation past year 9999, and the last minute before it
        send_date(14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, ADD_W'(1));
        send_date(14'd9990, 4'd1, 5'd1, 5'd0, 6'd0, {ADD_W{1'b1}});
        send_date(14'd9999, 4'd12, 5'd31, 5'd23, 6'd58, ADD_W'(1));
        // leap rules: every 400 years, not on centuries, every 4 years
        send_date(14'd2000, 4'd2, 5'd28, 5'd23, 6'd59, ADD_W'(1));
        send_date(14'd1900, 4'd2, 5'd28, 5'd23, 6'd59, ADD_W'(1));
        send_date(14'd2024, 4'd2, 5'd28, 5'd0, 6'd0, ADD_W'(1440));
        send_date(14'd0, 4'd2, 5'd29, 5'd12, 6'd30, '0);
        // month and year wraps
        send_date(14'd2023, 4'd12, 5'd31, 5'd23, 6'd59, ADD_W'(1));
        send_date(14'd2021, 4'd1, 5'd31, 5'd23, 6'd0, ADD_W'(60));
        send_date(14'd2021, 4'd4, 5'd30, 5'd0, 6'd0, ADD_W'(1440 * 365));
        // start year above range
        send_date(14'd16383, 4'd6, 5'd15, 5'd10, 6'd10, ADD_W'(100));
        // month out of range
        send_date(14'd2001, 4'd0, 5'd31, 5'd1, 6'd2, ADD_W'(1440 * 31));
        send_date(14'd2001, 4'd15, 5'd31, 5'd1, 6'd2, ADD_W'(1));
        // day out of range
        send_date(14'd2001, 4'd3, 5'd0, 5'd0, 6'd0, '0);
        send_date(14'd2001, 4'd4, 5'd31, 5'd0, 6'd0, '0);
        send_date(14'd2003, 4'd2, 5'd30, 5'd23, 6'd59, ADD_W'(1));
        // hour and minute out of range
        send_date(14'd1999, 4'd12, 5'd31, 5'd31, 6'd63, '0);
        send_date(14'd1999, 4'd12, 5'd31, 5'd31, 6'd63, ADD_W'(1));
        // every field at all ones
        send_date(14'h3FFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, {ADD_W{1'b1}});

        // random: mostly valid date-times, some raw noise
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM - NUM_QUIET)
                quiet = 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                y      = 14'($urandom());
                mon    = 4'($urandom());
                day    = 5'($urandom());
                hour   = 5'($urandom());
                minute = 6'($urandom());
            end else begin
                if (sel < 23)
                    y = 14'($urandom_range(9968, 9999));
                else if (sel < 38)
                    y = 14'(100 * $urandom_range(0, 99));
                else
                    y = 14'($urandom_range(0, 9999));
                mon  = 4'($urandom_range(1, 12));
                leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
                dim  = month_len(mon, leap);
                day  = ($urandom_range(0, 3) == 0) ? dim : 5'($urandom_range(1, dim));
                if ($urandom_range(0, 4) == 0) begin
                    hour   = HOUR_LAST;
                    minute = MINUTE_LAST;
                end else begin
                    hour   = 5'($urandom_range(0, 23));
                    minute = 6'($urandom_range(0, 59));
                end
            end
            sel = $urandom_range(0, 99);
            if (sel < 50)
                add = ADD_W'($urandom_range(0, 4095));
            else if (sel < 75)
                add = ADD_W'($urandom_range(0, (1 << 20) - 1));
            else if (sel < 85)
                add = ADD_W'(1440 * $urandom_range(0, 11000) + $urandom_range(0, 1));
            else
                add = ADD_W'($urandom());
            send_date(y, mon, day, hour, minute, add);
        end
        in_valid = 1'b0;

        // drain, then allow for a late spurious result
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("tb_date_time_add_minutes passed");
        else
            $display("tb_date_time_add_minutes failed");
        $finish;
    end

endmodule
